@@ hw/rtl/fdsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsu_pkg
// Shared widths, word codes and status codes of the data stack unit.
// ----------------------------------------------------------------------------
package fdsu_pkg;
  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned WordW = 32;
  localparam int unsigned CapW = 7;

  localparam logic [4:0] K_PUSH = 5'd0;
  localparam logic [4:0] K_POP = 5'd1;
  localparam logic [4:0] K_TOP = 5'd2;
  localparam logic [4:0] K_DUP = 5'd3;
  localparam logic [4:0] K_SWAP = 5'd4;
  localparam logic [4:0] K_ADD = 5'd5;
  localparam logic [4:0] K_SUB = 5'd6;
  localparam logic [4:0] K_MUL = 5'd7;
  localparam logic [4:0] K_DIV = 5'd8;
  localparam logic [4:0] K_DIVMOD = 5'd9;
  localparam logic [4:0] K_MOD = 5'd10;
  localparam logic [4:0] K_OVER = 5'd11;
  localparam logic [4:0] K_ROT = 5'd12;
  localparam logic [4:0] K_DROP = 5'd13;
  localparam logic [4:0] K_2SWAP = 5'd14;
  localparam logic [4:0] K_2DUP = 5'd15;
  localparam logic [4:0] K_2OVER = 5'd16;
  localparam logic [4:0] K_2DROP = 5'd17;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef struct packed {
    logic start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;

  // entries a word needs present
  function automatic logic [2:0] need_of(input logic [4:0] k);
    case (k)
      K_POP, K_DUP, K_DROP: need_of = 3'd1;
      K_ROT: need_of = 3'd3;
      K_2SWAP, K_2OVER: need_of = 3'd4;
      K_PUSH, K_TOP: need_of = 3'd0;
      default: need_of = (k <= K_2DROP) ? 3'd2 : 3'd0;
    endcase
  endfunction

  // entries a word adds
  function automatic logic [1:0] growth_of(input logic [4:0] k);
    case (k)
      K_PUSH, K_DUP, K_OVER: growth_of = 2'd1;
      K_2DUP, K_2OVER: growth_of = 2'd2;
      default: growth_of = 2'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/forth_data_stack_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// forth_data_stack_unit
// Bounded Forth data stack of signed 32-bit words with arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries push_operand, in_tuser the word code. One result per
//   word on out_: out_tuser is the status, out_tdata holds read_value then
//   depth_after. cfg_we/cfg_wdata set capacity_limit (reset 64).
//   The entries live in one single-port RAM. A word reads its operands one
//   entry a cycle (up to four reads, with registered read data), computes,
//   then writes results back one entry a cycle and reads the new top.
//   Div, mod and divmod wait on the bit-serial divider before writing back.
//   One word is in flight at a time.
//   The result sits in an output register; the next word is accepted only
//   once that result is taken, at the earliest in the cycle it is taken,
//   so a stalled receiver holds the input off.
//   Reset empties the stack (count to zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module forth_data_stack_unit #(
  parameter int unsigned STACK_DEPTH = fdsu_pkg::DefStackDepth
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // push_operand[31:0]
  input  wire [4:0]  in_tuser,   // kind[4:0]
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [39:0] out_tdata, // read_value[31:0], depth_after[38:32], pad
  output logic [1:0] out_tuser,  // status[1:0]
  input  wire        cfg_we,
  input  wire [6:0]  cfg_wdata   // capacity_limit[6:0]
);
  import fdsu_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_TOP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] newcnt_r, newcnt_nxt;
  logic [6:0]    cap_r;
  logic [4:0]    kind_r, kind_nxt;
  logic [31:0]   opnd_r, opnd_nxt;
  logic [31:0]   opv_r [4];  // opv_r[0] = top
  logic [31:0]   opv_nxt [4];
  logic [31:0]   wv_r [4], wv_nxt [4];  // wv_r[i]: value for slot i from new top
  logic [2:0]    nw_r, nw_nxt;   // entries to write
  logic [2:0]    step_r, step_nxt;
  logic          rdpend_r, rdpend_nxt;
  logic [31:0]   rv_r, rv_nxt;
  logic          haverd_r, haverd_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   ordv_r, ordv_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [CW-1:0] odep_r, odep_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  logic [CW:0]   effcap, need_dep;
  logic [2:0]    need;
  logic [1:0]    grow;
  logic [CW-1:0] addr_full;

  fdsu_ram #(.WIDTH(WordW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  fdsu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign need = need_of(kind_r);
  assign grow = growth_of(kind_r);
  assign effcap = (32'(cap_r) > STACK_DEPTH) ? (CW+1)'(STACK_DEPTH)
                  : (CW+1)'(cap_r);
  assign need_dep = {1'b0, cnt_r} + (CW+1)'(grow);
  assign in_tready = (state_r == S_IDLE) && !(ov_r && !out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    newcnt_nxt = newcnt_r;
    kind_nxt = kind_r;
    opnd_nxt = opnd_r;
    opv_nxt = opv_r;
    wv_nxt = wv_r;
    nw_nxt = nw_r;
    step_nxt = step_r;
    rdpend_nxt = 1'b0;
    rv_nxt = rv_r;
    haverd_nxt = haverd_r;
    st_nxt = st_r;
    ov_nxt = ov_r;
    ordv_nxt = ordv_r;
    ost_nxt = ost_r;
    odep_nxt = odep_r;
    ram_we = 1'b0;
    addr_full = '0;
    ram_wdata = '0;
    dreq.start = 1'b0;
    dreq.dividend = opv_r[1];
    dreq.divisor = opv_r[0];

    // drop delivered item
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          kind_nxt = in_tuser;
          opnd_nxt = in_tdata;
          step_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // capture last read, issue next
        if (rdpend_r) begin
          opv_nxt[2'(step_r - 3'd1)] = ram_rdata;
        end
        if (step_r < need && {1'b0, cnt_r} >= (CW+1)'(need)) begin
          addr_full = cnt_r - CW'(step_r) - CW'(1);
          rdpend_nxt = 1'b1;
          step_nxt = step_r + 3'd1;
        end else if (!rdpend_r || step_r >= need) begin
          if (!rdpend_r) state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        haverd_nxt = 1'b0;
        st_nxt = ST_OK;
        nw_nxt = '0;
        newcnt_nxt = cnt_r;
        state_nxt = S_TOP;
        if (kind_r > K_2DROP) begin
          st_nxt = ST_OK;
        end else if ({1'b0, cnt_r} < (CW+1)'(need)) begin
          st_nxt = ST_UNDER;
        end else if (grow != 2'd0 && need_dep > effcap) begin
          st_nxt = ST_OVER;
        end else if ((kind_r == K_DIV || kind_r == K_DIVMOD || kind_r == K_MOD)
                     && opv_r[0] == '0) begin
          st_nxt = ST_DIVZ;
        end else begin
          state_nxt = S_WRITE;
          step_nxt = '0;
          case (kind_r)
            K_PUSH: begin
              wv_nxt[0] = opnd_r; nw_nxt = 3'd1; newcnt_nxt = cnt_r + CW'(1);
            end
            K_POP, K_DROP: begin
              rv_nxt = opv_r[0]; haverd_nxt = 1'b1; newcnt_nxt = cnt_r - CW'(1);
            end
            K_DUP: begin
              wv_nxt[0] = opv_r[0]; nw_nxt = 3'd1; newcnt_nxt = cnt_r + CW'(1);
            end
            K_SWAP: begin
              wv_nxt[0] = opv_r[1]; wv_nxt[1] = opv_r[0]; nw_nxt = 3'd2;
            end
            K_ADD: begin
              wv_nxt[0] = opv_r[1] + opv_r[0]; nw_nxt = 3'd1;
              newcnt_nxt = cnt_r - CW'(1);
            end
            K_SUB: begin
              wv_nxt[0] = opv_r[1] - opv_r[0]; nw_nxt = 3'd1;
              newcnt_nxt = cnt_r - CW'(1);
            end
            K_MUL: begin
              wv_nxt[0] = 32'(opv_r[1] * opv_r[0]); nw_nxt = 3'd1;
              newcnt_nxt = cnt_r - CW'(1);
            end
            K_DIV, K_MOD: begin
              dreq.start = 1'b1; nw_nxt = 3'd1; newcnt_nxt = cnt_r - CW'(1);
              state_nxt = S_DIV;
            end
            K_DIVMOD: begin
              dreq.start = 1'b1; nw_nxt = 3'd2; state_nxt = S_DIV;
            end
            K_OVER: begin
              wv_nxt[0] = opv_r[1]; nw_nxt = 3'd1; newcnt_nxt = cnt_r + CW'(1);
            end
            K_ROT: begin
              wv_nxt[0] = opv_r[2]; wv_nxt[1] = opv_r[0]; wv_nxt[2] = opv_r[1];
              nw_nxt = 3'd3;
            end
            K_2SWAP: begin
              wv_nxt[0] = opv_r[2]; wv_nxt[1] = opv_r[3];
              wv_nxt[2] = opv_r[0]; wv_nxt[3] = opv_r[1]; nw_nxt = 3'd4;
            end
            K_2DUP: begin
              wv_nxt[0] = opv_r[0]; wv_nxt[1] = opv_r[1]; nw_nxt = 3'd2;
              newcnt_nxt = cnt_r + CW'(2);
            end
            K_2OVER: begin
              wv_nxt[0] = opv_r[2]; wv_nxt[1] = opv_r[3]; nw_nxt = 3'd2;
              newcnt_nxt = cnt_r + CW'(2);
            end
            K_2DROP: begin
              newcnt_nxt = cnt_r - CW'(2);
            end
            default: begin
              nw_nxt = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (kind_r == K_DIV) wv_nxt[0] = drsp.quot;
          else if (kind_r == K_MOD) wv_nxt[0] = drsp.rem;
          else begin
            wv_nxt[0] = drsp.quot; wv_nxt[1] = drsp.rem;
          end
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // write one entry a cycle, top first
        if (step_r < nw_r) begin
          ram_we = 1'b1;
          addr_full = newcnt_r - CW'(step_r) - CW'(1);
          ram_wdata = wv_r[step_r[1:0]];
          step_nxt = step_r + 3'd1;
        end else begin
          cnt_nxt = newcnt_r;
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        // read new top
        addr_full = cnt_r - CW'(1);
        rdpend_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          ost_nxt = st_r;
          odep_nxt = cnt_r;
          ordv_nxt = haverd_r ? rv_r : ((cnt_r == '0) ? 32'd0 : ram_rdata);
          state_nxt = S_IDLE;
        end else begin
          addr_full = cnt_r - CW'(1);
          rdpend_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_addr = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      cap_r <= 7'd64;
      ov_r <= 1'b0;
      rdpend_r <= 1'b0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      rdpend_r <= rdpend_nxt;
      step_r <= step_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
    newcnt_r <= newcnt_nxt;
    kind_r <= kind_nxt;
    opnd_r <= opnd_nxt;
    opv_r <= opv_nxt;
    wv_r <= wv_nxt;
    nw_r <= nw_nxt;
    rv_r <= rv_nxt;
    haverd_r <= haverd_nxt;
    st_r <= st_nxt;
    ordv_r <= ordv_nxt;
    ost_r <= ost_nxt;
    odep_r <= odep_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser = ost_r;
  assign out_tdata = {1'b0, 7'(odep_r), ordv_r};
endmodule
`default_nettype wire

@@ hw/rtl/fdsu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fdsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  addr,
  input  wire [WIDTH-1:0]          wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/fdsu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsu_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fdsu_div (
  input  wire                clk,
  input  wire                rst_n,
  input  fdsu_pkg::div_req_t req,
  output fdsu_pkg::div_rsp_t rsp
);
  import fdsu_pkg::*;

  logic [WordW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WordW:0]   rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic             nq_r, nq_nxt, nr_r, nr_nxt;
  logic [WordW:0]   trial;
  logic [WordW:0]   shifted;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    nq_nxt = nq_r;
    nr_nxt = nr_r;
    shifted = {rem_r[WordW-1:0], q_r[WordW-1]};
    trial = shifted - {1'b0, d_r};
    if (req.start) begin
      // load magnitudes
      q_nxt = req.dividend[WordW-1] ? -req.dividend : req.dividend;
      d_nxt = req.divisor[WordW-1] ? -req.divisor : req.divisor;
      rem_nxt = '0;
      cnt_nxt = 6'(WordW);
      busy_nxt = 1'b1;
      nq_nxt = req.dividend[WordW-1] ^ req.divisor[WordW-1];
      nr_nxt = req.dividend[WordW-1];
    end else if (busy_r) begin
      // one bit a cycle
      if (!trial[WordW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[WordW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[WordW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    nq_r <= nq_nxt;
    nr_r <= nr_nxt;
  end

  // apply signs
  assign rsp.done = done_r;
  assign rsp.quot = nq_r ? -q_r : q_r;
  assign rsp.rem = nr_r ? -rem_r[WordW-1:0] : rem_r[WordW-1:0];
endmodule
`default_nettype wire

@@ hw/rtl/fdsu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsu_checker
// Port-level checks of the data stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module fdsu_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire [1:0]  out_tuser
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result without an accepted item right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // accepted item is not answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // pad bit above depth_after is always zero
  a_dep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39] == 1'b0)
    else $error("pad bit set");
endmodule

bind forth_data_stack_unit fdsu_checker u_fdsu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire

@@ tb/sv/forth_data_stack_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_unit_checker
// Watches the word and result streams of the data stack unit. It keeps its
// own copy of the stack and the capacity, works out the expected status,
// value and depth of every accepted word, and compares each delivered
// result with the oldest expectation.
// ----------------------------------------------------------------------------
module forth_data_stack_unit_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [31:0] in_tdata,
  input  wire [4:0]  in_tuser,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [39:0] out_tdata,
  input  wire [1:0]  out_tuser,
  input  wire        cfg_we,
  input  wire [6:0]  cfg_wdata,
  output int         fail_count,
  output int         pending_count,
  output int         checked_count
);
  import fdsu_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  depth;
  } word_result_t;

  logic [31:0]  stack_mem [DefStackDepth];
  int unsigned  depth_now;
  int unsigned  capacity;
  word_result_t expected_results[$];
  int           errors;

  assign fail_count    = errors;
  assign pending_count = expected_results.size();

  // entry counted from the top, 1 is the top
  function automatic logic [31:0] peek(input int unsigned pos);
    return stack_mem[depth_now - pos];
  endfunction

  function automatic void poke(input int unsigned pos, input logic [31:0] v);
    stack_mem[depth_now - pos] = v;
  endfunction

  function automatic void push_entry(input logic [31:0] v);
    stack_mem[depth_now] = v;
    depth_now++;
  endfunction

  // signed quotient and remainder with truncation, MIN / -1 wraps
  function automatic void sdiv(input logic [31:0] a, input logic [31:0] b,
                               output logic [31:0] q, output logic [31:0] r);
    if (b == 32'hFFFF_FFFF) begin
      q = -a;
      r = '0;
    end else begin
      q = $signed(a) / $signed(b);
      r = $signed(a) % $signed(b);
    end
  endfunction

  // execute one word on the local stack copy
  function automatic word_result_t execute_word(input logic [4:0] kind,
                                                input logic [31:0] opnd);
    word_result_t res;
    int unsigned  needed;
    int unsigned  grows;
    int unsigned  lim;
    logic [31:0]  a, b, c, d, q, r;
    logic         removed;
    needed  = 0;
    grows   = 0;
    removed = 1'b0;
    res.status = ST_OK;
    res.value  = '0;
    case (kind)
      K_PUSH:                      grows = 1;
      K_POP, K_DROP:               needed = 1;
      K_DUP:                       begin needed = 1; grows = 1; end
      K_OVER:                      begin needed = 2; grows = 1; end
      K_2DUP:                      begin needed = 2; grows = 2; end
      K_2OVER:                     begin needed = 4; grows = 2; end
      K_ROT:                       needed = 3;
      K_2SWAP:                     needed = 4;
      K_SWAP, K_ADD, K_SUB, K_MUL, K_DIV, K_DIVMOD, K_MOD, K_2DROP:
                                   needed = 2;
      default:                     needed = 0;
    endcase
    lim = (capacity > DefStackDepth) ? DefStackDepth : capacity;
    if (kind <= K_2DROP) begin
      if (depth_now < needed) begin
        res.status = ST_UNDER;
      end else if (grows != 0 && depth_now + grows > lim) begin
        res.status = ST_OVER;
      end else if ((kind == K_DIV || kind == K_DIVMOD || kind == K_MOD) &&
                   peek(1) == 0) begin
        res.status = ST_DIVZ;
      end
    end
    // apply the word only when it succeeds
    if (res.status == ST_OK && kind <= K_2DROP) begin
      case (kind)
        K_PUSH: push_entry(opnd);
        K_POP, K_DROP: begin
          res.value = peek(1);
          removed = 1'b1;
          depth_now--;
        end
        K_TOP: begin
          removed = 1'b0;
        end
        K_DUP: push_entry(peek(1));
        K_SWAP: begin
          a = peek(2); b = peek(1);
          poke(2, b); poke(1, a);
        end
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD: begin
          a = peek(2); b = peek(1);
          sdiv(a, b, q, r);
          case (kind)
            K_ADD:   c = a + b;
            K_SUB:   c = a - b;
            K_MUL:   c = a * b;
            K_DIV:   c = q;
            default: c = r;
          endcase
          depth_now--;
          poke(1, c);
        end
        K_DIVMOD: begin
          a = peek(2); b = peek(1);
          sdiv(a, b, q, r);
          poke(2, r); poke(1, q);
        end
        K_OVER: push_entry(peek(2));
        K_ROT: begin
          a = peek(3); b = peek(2); c = peek(1);
          poke(3, b); poke(2, c); poke(1, a);
        end
        K_2SWAP: begin
          a = peek(4); b = peek(3); c = peek(2); d = peek(1);
          poke(4, c); poke(3, d); poke(2, a); poke(1, b);
        end
        K_2DUP: begin
          a = peek(2); b = peek(1);
          push_entry(a); push_entry(b);
        end
        K_2OVER: begin
          a = peek(4); b = peek(3);
          push_entry(a); push_entry(b);
        end
        default: depth_now -= 2;
      endcase
    end
    if (!removed) res.value = (depth_now > 0) ? peek(1) : '0;
    res.depth = depth_now[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    word_result_t want;
    if (!rst_n) begin
      depth_now     = 0;
      capacity      = 64;
      errors        = 0;
      checked_count = 0;
      expected_results.delete();
    end else begin
      // compare a delivered result first: it belongs to an earlier word
      if (out_tvalid && out_tready) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          $error("result with no word outstanding: status %0d value %h depth %0d",
                 out_tuser, out_tdata[31:0], out_tdata[38:32]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata[31:0] !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[38:32] !== want.depth) begin
            $error("depth_after: expected %0d, got %0d", want.depth, out_tdata[38:32]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(execute_word(in_tuser, in_tdata));
      if (cfg_we) capacity = cfg_wdata;
    end
  end

endmodule

@@ tb/sv/forth_data_stack_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_unit_tb
// Drives stack words into the data stack unit under several capacities:
// a directed opening over edge values and every word, then long runs that
// alternately fill and drain the stack, with random idling on both sides
// and one long output stall. A checker module scores every result.
// ----------------------------------------------------------------------------
module forth_data_stack_unit_tb;
  import fdsu_pkg::*;

  localparam int StallLimit  = 3000;
  localparam int SettleWait  = 60;
  localparam int LongHold    = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  int fail_count, pending_count, checked_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int words_sent = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;
  bit fill_mode = 1'b1;
  int mode_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  forth_data_stack_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  forth_data_stack_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .checked_count(checked_count)
  );

  // result side: random stalls, or a long hold once armed
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_armed <= 1'b0;
      hold_left  <= LongHold;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one word, idling at random first, and hold it until taken
  task automatic send_word(input logic [4:0] kind, input logic [31:0] opnd);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = opnd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    words_sent++;
  endtask

  // wait for every result, let the block settle, then set the capacity
  task automatic set_capacity(input logic [6:0] cap);
    while (pending_count != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // mostly fill or mostly drain, switching every few dozen words
  task automatic send_random(input int count);
    logic [4:0] kind;
    int         roll;
    repeat (count) begin
      if (mode_left == 0) begin
        fill_mode = ~fill_mode;
        mode_left = $urandom_range(30, 90);
      end
      mode_left--;
      roll = $urandom_range(99);
      if (roll < 3)
        kind = 5'($urandom_range(18, 31));
      else if (roll < (fill_mode ? 50 : 15))
        kind = K_PUSH;
      else if (!fill_mode && roll < 40) begin
        case ($urandom_range(2))
          0:       kind = K_POP;
          1:       kind = K_DROP;
          default: kind = K_2DROP;
        endcase
      end else
        kind = 5'($urandom_range(0, 17));
      send_word(kind, (kind == K_PUSH) ? pick_operand() : $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_capacity(7'd64);

    // directed: empty stack, edge values, wrap cases, every word
    send_word(K_TOP, 32'h0);
    send_word(K_POP, 32'h0);
    send_word(K_ADD, 32'h0);
    send_word(K_PUSH, 32'h8000_0000);
    send_word(K_PUSH, 32'hFFFF_FFFF);
    send_word(K_DIVMOD, 32'h0);
    send_word(K_PUSH, 32'h0);
    send_word(K_MOD, 32'h0);
    send_word(K_DROP, 32'h0);
    send_word(K_PUSH, 32'h7FFF_FFFF);
    send_word(K_DUP, 32'h0);
    send_word(K_ADD, 32'h0);
    send_word(K_PUSH, 32'hFFFF_FFF9);
    for (int k = K_POP; k <= K_2DROP; k++) begin
      send_word(K_PUSH, $urandom);
      send_word(k[4:0], 32'hFFFF_FFFF);
    end
    send_word(5'd31, 32'h0);

    // nothing may grow at capacity zero
    set_capacity(7'd0);
    tx_idle_pct = 37;
    rx_idle_pct = 69;
    send_random(40);

    // capacity above the array size saturates
    set_capacity(7'd127);
    send_random(480);

    // a small capacity, usually below the depth already reached
    set_capacity(7'd5);
    tx_idle_pct = 69;
    rx_idle_pct = 37;
    send_random(480);

    // full capacity, no idling, and one long output hold
    set_capacity(7'd64);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_mode = 1'b1;
    mode_left = 120;
    send_random(60);
    hold_armed = 1'b1;
    send_random(440);

    while (pending_count != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);

    $display("Sent %0d stack words over capacities 64, 0, 127, 5 and 64;", words_sent);
    $display("checked %0d results with idling on both sides and a long stall.",
             checked_count);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
